// ----- hw/rtl/json_string_unescape_utf8_unit_defines.svh -----
// assertion macros used by the checker file jsu_checker.sv
// no dependencies; take in by `include with the bare file name
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

// concurrent assertion clocked on rising edge, off while reset is low
`define JSU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, but also evaluated while reset is asserted
`define JSU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/jsu_pkg.sv -----
// types, constants and helper functions of the json string unescaper
// no dependencies
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_HIGH,
    PH_HIGH_BS,
    PH_LOW_HEX
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // one queued result word
  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } res_t;

  // utf-8 sequence of one code point
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_t;

  localparam logic [7:0]  ChQuote = 8'h22;
  localparam logic [7:0]  ChBslash = 8'h5c;
  localparam logic [7:0]  ChU = 8'h75;
  localparam logic [15:0] HighMin = 16'hd800;
  localparam logic [15:0] HighMax = 16'hdbff;
  localparam logic [15:0] LowMin = 16'hdc00;
  localparam logic [15:0] LowMax = 16'hdfff;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [20:0] Max1 = 21'h7f;
  localparam logic [20:0] Max2 = 21'h7ff;
  localparam logic [20:0] Max3 = 21'hffff;
  localparam logic [7:0]  Lead2 = 8'hc0;
  localparam logic [7:0]  Lead3 = 8'he0;
  localparam logic [7:0]  Lead4 = 8'hf0;
  localparam logic [7:0]  ContMark = 8'h80;
  localparam int unsigned MaxRes = 4;

  // hex digit value, bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = 5'(b[3:0]) + 5'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] escape_char(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h6e:   c = 8'h0a;
      8'h74:   c = 8'h09;
      8'h72:   c = 8'h0d;
      8'h62:   c = 8'h08;
      8'h66:   c = 8'h0c;
      default: c = b;
    endcase
    return c;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t e;
    e = '0;
    if (cp <= Max1) begin
      e.len      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= Max2) begin
      e.len      = 3'd2;
      e.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      e.bytes[1] = ContMark | {2'b00, cp[5:0]};
    end else if (cp <= Max3) begin
      e.len      = 3'd3;
      e.bytes[0] = Lead3 | {4'h0, cp[15:12]};
      e.bytes[1] = ContMark | {2'b00, cp[11:6]};
      e.bytes[2] = ContMark | {2'b00, cp[5:0]};
    end else begin
      e.len      = 3'd4;
      e.bytes[0] = Lead4 | {5'h00, cp[20:18]};
      e.bytes[1] = ContMark | {2'b00, cp[17:12]};
      e.bytes[2] = ContMark | {2'b00, cp[11:6]};
      e.bytes[3] = ContMark | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ----- hw/rtl/jsu_if.sv -----
// valid/ready channel interfaces for raw input bytes and decoded results
// no dependencies
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, in_byte, in_end, input ready);
  modport sink (input valid, in_byte, in_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last;

  modport source (output valid, out_byte, out_status, out_last, input ready);
  modport sink (input valid, out_byte, out_status, out_last, output ready);
endinterface

// ----- hw/rtl/json_string_unescape_utf8_unit.sv -----
// streaming json string unescaper with utf-8 output
// depends on jsu_pkg and the channel interfaces in jsu_if.sv
//
// usage:
//  - in_i carries one raw byte of a quoted string per word, starting at the
//    opening quote; in_end marks the last byte of available data
//  - out_o carries decoded words: a utf-8 byte (status 0), string done
//    (status 1) or error (status 2); out_last flags the final word caused by
//    one input byte; after an error the bytes already sent must be dropped
//  - path: an accepted byte lands in the input register, is decoded from
//    there once the result queue has room, and its result words are
//    written to the result queue, whose head word is shown on out_o
//  - throughput: one input byte per cycle while each byte yields at most one
//    word and the receiver keeps taking words; a byte yields up to four words
//    (surrogate pairs, lone high surrogates), which the result queue absorbs
//    and the output drains at one word per cycle while out_o is ready
//  - the input register hands its byte to the decoder only when the result
//    queue has room for four words, so a stalled receiver fills the queue
//    and then back-pressures in_i
//  - reset (rst_ni low, asynchronous) empties the queue and returns the
//    decoder to waiting for an opening quote
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
#(
  // result queue depth, a power of two, at least 8
  parameter int unsigned FifoDepth = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jsu_in_if.sink       in_i,
  jsu_out_if.source    out_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // decoder state
  phase_e      phase_q, phase_d;
  logic [15:0] cu_q, cu_d;
  logic [15:0] hu_q, hu_d;
  logic [1:0]  hc_q, hc_d;

  // result queue
  res_t            fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic room, take, in_acc, pop;

  // queue must hold the worst case of one byte before the decoder takes it
  assign room   = cnt_q <= CntW'(FifoDepth - MaxRes);
  assign take   = in_vld_q && room;
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = !in_vld_q || room;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (take) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.in_byte;
      in_end_q  <= in_i.in_end;
    end
  end

  // shared decode terms
  logic [4:0]  nib;
  logic        hex_bad;
  logic [15:0] cu_new;
  logic        hex_full;
  logic        is_high, is_low;
  logic [20:0] pair_cp;

  assign nib      = hex_val(in_byte_q);
  assign hex_bad  = in_end_q || nib[4];
  assign cu_new   = {cu_q[11:0], nib[3:0]};
  assign hex_full = hc_q == 2'd3;
  assign is_high  = cu_new >= HighMin && cu_new <= HighMax;
  assign is_low   = cu_new >= LowMin && cu_new <= LowMax;
  // high unit is known to be a high surrogate here
  assign pair_cp  = SuppBase + {1'b0, hu_q[9:0], cu_new[9:0]};

  // next state
  always_comb begin
    phase_d = phase_q;
    cu_d    = cu_q;
    hu_d    = hu_q;
    hc_d    = hc_q;
    case (phase_q)
      PH_BODY, PH_HIGH: begin
        if (in_byte_q == ChQuote || in_end_q) begin
          phase_d = PH_IDLE;
          cu_d    = '0;
          hc_d    = '0;
        end else if (in_byte_q == ChBslash) begin
          phase_d = (phase_q == PH_HIGH) ? PH_HIGH_BS : PH_ESC;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_ESC, PH_HIGH_BS: begin
        if (in_end_q) begin
          phase_d = PH_IDLE;
          cu_d    = '0;
          hc_d    = '0;
        end else if (in_byte_q == ChU) begin
          phase_d = (phase_q == PH_HIGH_BS) ? PH_LOW_HEX : PH_HEX;
          cu_d    = '0;
          hc_d    = '0;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_HEX, PH_LOW_HEX: begin
        if (hex_bad) begin
          phase_d = PH_IDLE;
          cu_d    = '0;
          hc_d    = '0;
        end else begin
          cu_d = cu_new;
          hc_d = hc_q + 2'd1;
          if (hex_full) begin
            if (phase_q == PH_HEX) begin
              if (is_high) begin
                hu_d    = cu_new;
                phase_d = PH_HIGH;
              end else begin
                phase_d = PH_BODY;
              end
            end else if (is_low) begin
              phase_d = PH_BODY;
            end else begin
              // bad low surrogate
              phase_d = PH_IDLE;
              cu_d    = '0;
              hc_d    = '0;
            end
          end
        end
      end
      default: begin
        cu_d = '0;
        hc_d = '0;
        if (in_byte_q == ChQuote && !in_end_q) begin
          phase_d = PH_BODY;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // what this byte emits: error, an encoded code point, and one more word
  logic        fail_s;
  logic        enc_en;
  logic [20:0] enc_cp;
  logic        ext_en;
  res_t        ext_res;

  always_comb begin
    fail_s  = 1'b0;
    enc_en  = 1'b0;
    enc_cp  = {5'h00, hu_q};
    ext_en  = 1'b0;
    ext_res = '{data: in_byte_q, status: ST_BYTE, last: 1'b0};
    case (phase_q)
      PH_BODY, PH_HIGH: begin
        if (in_byte_q == ChQuote) begin
          enc_en  = phase_q == PH_HIGH;
          ext_en  = 1'b1;
          ext_res = '{data: 8'h00, status: ST_DONE, last: 1'b0};
        end else if (in_end_q) begin
          fail_s = 1'b1;
        end else if (in_byte_q != ChBslash) begin
          enc_en = phase_q == PH_HIGH;
          ext_en = 1'b1;
        end
      end
      PH_ESC, PH_HIGH_BS: begin
        if (in_end_q) begin
          fail_s = 1'b1;
        end else if (in_byte_q != ChU) begin
          enc_en  = phase_q == PH_HIGH_BS;
          ext_en  = 1'b1;
          ext_res = '{data: escape_char(in_byte_q), status: ST_BYTE, last: 1'b0};
        end
      end
      PH_HEX: begin
        if (hex_bad) begin
          fail_s = 1'b1;
        end else if (hex_full && !is_high) begin
          enc_en = 1'b1;
          enc_cp = {5'h00, cu_new};
        end
      end
      PH_LOW_HEX: begin
        if (hex_bad || (hex_full && !is_low)) begin
          fail_s = 1'b1;
        end else if (hex_full) begin
          enc_en = 1'b1;
          enc_cp = pair_cp;
        end
      end
      default: begin
        fail_s = !(in_byte_q == ChQuote && !in_end_q);
      end
    endcase
  end

  // assemble up to four result words
  utf8_t enc;
  res_t  res [MaxRes];
  logic [2:0] res_n;

  assign enc = utf8_encode(enc_cp);

  always_comb begin
    res_n = 3'd0;
    for (int k = 0; k < MaxRes; k++) begin
      res[k] = '{data: enc.bytes[k], status: ST_BYTE, last: 1'b0};
    end
    if (fail_s) begin
      res[0] = '{data: 8'h00, status: ST_ERROR, last: 1'b0};
      res_n  = 3'd1;
    end else begin
      if (enc_en) begin
        res_n = enc.len;
      end
      // extra word follows no word or a 3-byte surrogate, so the slot fits
      if (ext_en) begin
        res[res_n[1:0]] = ext_res;
        res_n = res_n + 3'd1;
      end
    end
    if (res_n != 3'd0) begin
      res[2'(res_n - 3'd1)].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cu_q    <= '0;
      hu_q    <= '0;
      hc_q    <= '0;
    end else if (take) begin
      phase_q <= phase_d;
      cu_q    <= cu_d;
      hu_q    <= hu_d;
      hc_q    <= hc_d;
    end
  end

  // result queue
  logic [2:0] push_n;

  assign push_n = take ? res_n : 3'd0;
  assign pop    = out_o.valid && out_o.ready;
  assign cnt_d  = cnt_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (3'(k) < push_n) begin
        fifo_q[wr_ptr_q + PtrW'(k)] <= res[k];
      end
    end
  end

  assign out_o.valid      = cnt_q != '0;
  assign out_o.out_byte   = fifo_q[rd_ptr_q].data;
  assign out_o.out_status = fifo_q[rd_ptr_q].status;
  assign out_o.out_last   = fifo_q[rd_ptr_q].last;

endmodule

// ----- hw/rtl/jsu_checker.sv -----
// port-level checks of the json string unescaper, bound to the top level
// depends on jsu_pkg and json_string_unescape_utf8_unit_defines.svh
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] out_status_i,
  input logic       out_last_i
);

  // a stalled word holds its payload
  `JSU_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_status_i) && $stable(out_last_i), "stalled output word changed")

  // done and error always end the words of their input byte
  `JSU_ASSERT(a_term_last, clk_i, rst_ni,
    out_valid_i && out_status_i != ST_BYTE |-> out_last_i, "done or error word not last")

  // done and error carry a zero byte
  `JSU_ASSERT(a_term_zero, clk_i, rst_ni,
    out_valid_i && out_status_i != ST_BYTE |-> out_byte_i == 8'h00,
    "done or error word with nonzero byte")

  // only the three defined status codes appear
  `JSU_ASSERT(a_status_code, clk_i, rst_ni,
    out_valid_i |-> out_status_i == ST_BYTE || out_status_i == ST_DONE
      || out_status_i == ST_ERROR, "undefined status code")

  // the queue is empty while reset is held
  `JSU_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_i,
    "output word during reset")

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .out_status_i (out_o.out_status),
  .out_last_i   (out_o.out_last)
);
